### sv/tbit_pkg.sv
// ----------------------------------------------------------------------------
// tbit_pkg
// shared constants for the barycentric point-in-triangle test
// ----------------------------------------------------------------------------
`default_nettype none

package tbit_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_Y = 3'd5;

    localparam int WEIGHT_W    = 32;
    localparam int QUO_W       = 33;
    localparam int DIV_LAT     = QUO_W + 1;
    localparam int OUT_TDATA_W = 104;

endpackage

`default_nettype wire

### sv/tbit_front.sv
// ----------------------------------------------------------------------------
// tbit_front
// differences, products, sums and magnitudes of the numerators and determinant
// ----------------------------------------------------------------------------
`default_nettype none

module tbit_front #(
    parameter int C  = 16,
    parameter int NW = 2 * C + 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire logic signed [C-1:0]  px,
    input  wire logic signed [C-1:0]  py,
    input  wire logic signed [C-1:0]  ax,
    input  wire logic signed [C-1:0]  ay,
    input  wire logic signed [C-1:0]  bx,
    input  wire logic signed [C-1:0]  by,
    input  wire logic signed [C-1:0]  cx,
    input  wire logic signed [C-1:0]  cy,
    output logic                      out_valid,
    output logic                      out_degen,
    output logic [NW-1:0]             na_mag,
    output logic                      na_neg,
    output logic [NW-1:0]             nb_mag,
    output logic                      nb_neg,
    output logic [NW-1:0]             d_mag,
    output logic                      d_neg
);

    logic [3:0] v_reg;

    // stage 1: differences
    logic signed [C:0] e_bc_y_reg, e_cb_x_reg, e_ca_y_reg, e_ac_x_reg, e_pc_x_reg, e_pc_y_reg;
    // stage 2: products
    logic signed [2*C+1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    // stage 3: sums
    logic signed [NW-1:0] det_reg, na_reg, nb_reg;
    // stage 4: magnitudes
    logic [NW-1:0] na_mag_reg, nb_mag_reg, d_mag_reg;
    logic          na_neg_reg, nb_neg_reg, d_neg_reg, degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            e_bc_y_reg <= (C+1)'(by) - (C+1)'(cy);
            e_cb_x_reg <= (C+1)'(cx) - (C+1)'(bx);
            e_ca_y_reg <= (C+1)'(cy) - (C+1)'(ay);
            e_ac_x_reg <= (C+1)'(ax) - (C+1)'(cx);
            e_pc_x_reg <= (C+1)'(px) - (C+1)'(cx);
            e_pc_y_reg <= (C+1)'(py) - (C+1)'(cy);

            p0_reg <= e_bc_y_reg * e_ac_x_reg;
            p1_reg <= e_cb_x_reg * e_ca_y_reg;
            p2_reg <= e_bc_y_reg * e_pc_x_reg;
            p3_reg <= e_cb_x_reg * e_pc_y_reg;
            p4_reg <= e_ca_y_reg * e_pc_x_reg;
            p5_reg <= e_ac_x_reg * e_pc_y_reg;

            // ay - cy = -(cy - ay)
            det_reg <= NW'(p0_reg) - NW'(p1_reg);
            na_reg  <= NW'(p2_reg) + NW'(p3_reg);
            nb_reg  <= NW'(p4_reg) + NW'(p5_reg);

            na_neg_reg <= na_reg[NW-1];
            nb_neg_reg <= nb_reg[NW-1];
            d_neg_reg  <= det_reg[NW-1];
            na_mag_reg <= na_reg[NW-1] ? NW'(-na_reg) : NW'(na_reg);
            nb_mag_reg <= nb_reg[NW-1] ? NW'(-nb_reg) : NW'(nb_reg);
            d_mag_reg  <= det_reg[NW-1] ? NW'(-det_reg) : NW'(det_reg);
            degen_reg  <= (det_reg == '0);
        end
    end

    assign out_valid = v_reg[3];
    assign out_degen = degen_reg;
    assign na_mag    = na_mag_reg;
    assign na_neg    = na_neg_reg;
    assign nb_mag    = nb_mag_reg;
    assign nb_neg    = nb_neg_reg;
    assign d_mag     = d_mag_reg;
    assign d_neg     = d_neg_reg;

endmodule

`default_nettype wire

### sv/tbit_divider.sv
// ----------------------------------------------------------------------------
// tbit_divider
// pipelined restoring divider, one quotient bit per stage, overflow check
// ----------------------------------------------------------------------------
`default_nettype none

module tbit_divider #(
    parameter int NW = 35,
    parameter int F  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         ce,
    input  wire logic [NW-1:0]                n_mag,
    input  wire logic [NW-1:0]                d_mag,
    input  wire logic                         neg,
    output logic [tbit_pkg::QUO_W-1:0]        quo,
    output logic                              rem_nz,
    output logic                              ovf,
    output logic                              quo_neg
);

    import tbit_pkg::*;

    localparam int EW = NW + F + QUO_W;

    logic [EW-1:0] ext_n, ext_d;

    logic [NW-1:0]    r_reg   [0:QUO_W];
    logic [NW-1:0]    d_reg   [0:QUO_W];
    logic [QUO_W-1:0] lo_reg  [0:QUO_W];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];
    logic             ovf_reg [0:QUO_W];
    logic             neg_reg [0:QUO_W];

    assign ext_n = EW'({n_mag, {F{1'b0}}});
    assign ext_d = EW'({d_mag, {QUO_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_reg[0]   <= ext_n[QUO_W +: NW];
            lo_reg[0]  <= ext_n[QUO_W-1:0];
            d_reg[0]   <= d_mag;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (ext_n >= ext_d);
            neg_reg[0] <= neg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_step
            logic [NW:0] r2;
            logic [NW:0] diff;
            logic        ge;

            always_comb
            begin
                r2   = {r_reg[k], lo_reg[k][QUO_W-1]};
                diff = r2 - {1'b0, d_reg[k]};
                ge   = (r2 >= {1'b0, d_reg[k]});
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    r_reg[k+1]   <= ge ? diff[NW-1:0] : r2[NW-1:0];
                    lo_reg[k+1]  <= {lo_reg[k][QUO_W-2:0], 1'b0};
                    q_reg[k+1]   <= {q_reg[k][QUO_W-2:0], ge};
                    d_reg[k+1]   <= d_reg[k];
                    ovf_reg[k+1] <= ovf_reg[k];
                    neg_reg[k+1] <= neg_reg[k];
                end
            end
        end
    endgenerate

    assign quo     = q_reg[QUO_W];
    assign rem_nz  = (r_reg[QUO_W] != '0);
    assign ovf     = ovf_reg[QUO_W];
    assign quo_neg = neg_reg[QUO_W];

endmodule

`default_nettype wire

### sv/triangle_barycentric_inside_test.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_inside_test
// barycentric weights of a point against a configured triangle, inside flag
// ----------------------------------------------------------------------------
// channel   dir  handshake              contents
// s_*       in   s_tvalid / s_tready    point_x, point_y
// m_*       out  m_tvalid / m_tready    weight_a, weight_b, weight_c, inside_res, degenerate
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data (vertex registers)
//
// one item per cycle while the output is not stalled: 4 front stages, 34 divider
// stages (an input stage, then one quotient bit per stage), 2 output stages
// the whole pipeline advances when the output register is empty or taken
// reset clears the vertex registers and all valid bits
// cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_barycentric_inside_test #(
    parameter int COORD_WIDTH      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // point_x, point_y
    input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // weight_a, weight_b, weight_c, inside_res, degenerate
    output logic [tbit_pkg::OUT_TDATA_W-1:0]             m_tdata,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [tbit_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [COORD_WIDTH-1:0]                  cfg_data
);

    import tbit_pkg::*;

    localparam int C  = COORD_WIDTH;
    localparam int NW = 2 * C + 3;

    logic signed [C-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic                ce;

    logic          f_valid, f_degen, na_neg, nb_neg, d_neg;
    logic [NW-1:0] na_mag, nb_mag, d_mag;

    logic [QUO_W-1:0] qa, qb;
    logic             ra_nz, rb_nz, ova, ovb, nega, negb;

    logic [DIV_LAT-1:0] dv_reg;
    logic [DIV_LAT-1:0] dg_reg;

    logic                       sa_valid_reg, sa_degen_reg;
    logic signed [WEIGHT_W-1:0] wa_reg, wb_reg;
    logic signed [WEIGHT_W-1:0] wa_next, wb_next;

    logic                       m_valid_reg;
    logic [OUT_TDATA_W-1:0]     m_data_reg;
    logic signed [WEIGHT_W+1:0] wc_wide;
    logic signed [WEIGHT_W-1:0] wc_sat;
    logic                       in_tri;

    assign ce        = !m_valid_reg || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_A_X: ax_reg <= cfg_data;
                REG_A_Y: ay_reg <= cfg_data;
                REG_B_X: bx_reg <= cfg_data;
                REG_B_Y: by_reg <= cfg_data;
                REG_C_X: cx_reg <= cfg_data;
                REG_C_Y: cy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tbit_front #(.C(C), .NW(NW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .px        (s_tdata[C-1:0]),
        .py        (s_tdata[2*C-1:C]),
        .ax        (ax_reg),
        .ay        (ay_reg),
        .bx        (bx_reg),
        .by        (by_reg),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .out_valid (f_valid),
        .out_degen (f_degen),
        .na_mag    (na_mag),
        .na_neg    (na_neg),
        .nb_mag    (nb_mag),
        .nb_neg    (nb_neg),
        .d_mag     (d_mag),
        .d_neg     (d_neg)
    );

    tbit_divider #(.NW(NW), .F(WEIGHT_FRAC_BITS)) u_div_a (
        .clk     (clk),
        .ce      (ce),
        .n_mag   (na_mag),
        .d_mag   (d_mag),
        .neg     (na_neg != d_neg),
        .quo     (qa),
        .rem_nz  (ra_nz),
        .ovf     (ova),
        .quo_neg (nega)
    );

    tbit_divider #(.NW(NW), .F(WEIGHT_FRAC_BITS)) u_div_b (
        .clk     (clk),
        .ce      (ce),
        .n_mag   (nb_mag),
        .d_mag   (d_mag),
        .neg     (nb_neg != d_neg),
        .quo     (qb),
        .rem_nz  (rb_nz),
        .ovf     (ovb),
        .quo_neg (negb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else if (ce)
        begin
            dv_reg <= {dv_reg[DIV_LAT-2:0], f_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dg_reg <= {dg_reg[DIV_LAT-2:0], f_degen};
        end
    end

    function automatic logic signed [WEIGHT_W-1:0] sat_weight(
        input logic [QUO_W-1:0] q,
        input logic             rnz,
        input logic             ov,
        input logic             ng
    );
        logic [QUO_W:0] qq;
        logic signed [WEIGHT_W-1:0] w;
        qq = (QUO_W+1)'(q) + (QUO_W+1)'(rnz);
        if (ng)
        begin
            if (ov || qq > (QUO_W+1)'(34'h0_8000_0000))
                w = {1'b1, {(WEIGHT_W-1){1'b0}}};
            else
                w = WEIGHT_W'(-qq);
        end
        else
        begin
            if (ov || q > QUO_W'(33'h0_7FFF_FFFF))
                w = {1'b0, {(WEIGHT_W-1){1'b1}}};
            else
                w = q[WEIGHT_W-1:0];
        end
        return w;
    endfunction

    assign wa_next = sat_weight(qa, ra_nz, ova, nega);
    assign wb_next = sat_weight(qb, rb_nz, ovb, negb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            sa_valid_reg <= dv_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sa_degen_reg <= dg_reg[DIV_LAT-1];
            wa_reg       <= wa_next;
            wb_reg       <= wb_next;
        end
    end

    always_comb
    begin
        wc_wide = ((WEIGHT_W+2)'(1) <<< WEIGHT_FRAC_BITS)
                  - (WEIGHT_W+2)'(wa_reg) - (WEIGHT_W+2)'(wb_reg);
        if (wc_wide > (WEIGHT_W+2)'(34'sh0_7FFF_FFFF))
            wc_sat = {1'b0, {(WEIGHT_W-1){1'b1}}};
        else if (wc_wide < -(WEIGHT_W+2)'(34'sh0_8000_0000))
            wc_sat = {1'b1, {(WEIGHT_W-1){1'b0}}};
        else
            wc_sat = wc_wide[WEIGHT_W-1:0];
        in_tri = !wa_reg[WEIGHT_W-1] && !wb_reg[WEIGHT_W-1] && !wc_sat[WEIGHT_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            m_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (sa_degen_reg)
                m_data_reg <= OUT_TDATA_W'({1'b1, 1'b0, {(3*WEIGHT_W){1'b0}}});
            else
                m_data_reg <= OUT_TDATA_W'({1'b0, in_tri, wc_sat, wb_reg, wa_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3*WEIGHT_W+1] |-> m_tdata[3*WEIGHT_W:0] == '0)
        else $error("degenerate result with nonzero weights");

    a_inside_signs : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3*WEIGHT_W] |->
            !m_tdata[WEIGHT_W-1] && !m_tdata[2*WEIGHT_W-1] && !m_tdata[3*WEIGHT_W-1])
        else $error("inside set with a negative weight");

    a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(dv_reg) && $stable(sa_valid_reg))
        else $error("pipeline moved during stall");

    a_accept_tracks : assert property (@(posedge clk) disable iff (!rst_n)
        ce && sa_valid_reg |=> m_valid_reg)
        else $error("result lost at output stage");

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the barycentric point-in-triangle block. It queries the reset
// triangle, then sets triangles through the register channel: a plain one, the
// extreme corners, a collinear one, a tiny one that drives the weights into
// saturation, and random ones. Each gets directed query points, random ones or
// both, directed first. Both stream sides idle at random.
// A scoreboard predicts the floored Q16.16 weights and the inside and
// degenerate flags of every accepted point and checks each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import tbit_pkg::*;

typedef struct packed {
    logic [31:0] weight_a;
    logic [31:0] weight_b;
    logic [31:0] weight_c;
    logic        inside_res;
    logic        degenerate;
} weights_t;

class tri_scoreboard;
    logic signed [15:0] vtx [6];
    weights_t           pending_q [$];
    int                 errors;

    function new();
        foreach (vtx[i]) vtx[i] = '0;
        errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        if (idx <= REG_C_Y) vtx[idx] = value;
    endfunction

    // floored quotient with 16 fractional bits, clamped to 32 bits
    function longint floor_weight(longint num, longint den);
        longint n;
        longint q;
        n = num * 65536;
        q = n / den;
        if ((n % den) != 0 && ((n < 0) != (den < 0))) q = q - 1;
        return clamp32(q);
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function void note_point(logic [15:0] px_raw, logic [15:0] py_raw);
        longint ax, ay, bx, by, cx, cy, px, py, det, wa, wb, wc;
        weights_t w;
        ax = longint'(vtx[REG_A_X]); ay = longint'(vtx[REG_A_Y]);
        bx = longint'(vtx[REG_B_X]); by = longint'(vtx[REG_B_Y]);
        cx = longint'(vtx[REG_C_X]); cy = longint'(vtx[REG_C_Y]);
        px = longint'($signed(px_raw));
        py = longint'($signed(py_raw));
        det = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
        w = '0;
        if (det == 0) begin
            w.degenerate = 1'b1;
        end
        else begin
            wa = floor_weight((by - cy) * (px - cx) + (cx - bx) * (py - cy), det);
            wb = floor_weight((cy - ay) * (px - cx) + (ax - cx) * (py - cy), det);
            wc = clamp32(65536 - wa - wb);
            w.weight_a   = wa[31:0];
            w.weight_b   = wb[31:0];
            w.weight_c   = wc[31:0];
            w.inside_res = (wa >= 0 && wb >= 0 && wc >= 0);
        end
        pending_q.push_back(w);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata);
        weights_t want;
        if (pending_q.size() == 0) begin
            report("unexpected item", tdata[31:0], 32'd0);
            return;
        end
        want = pending_q.pop_front();
        if (tdata[31:0] !== want.weight_a) report("weight_a", tdata[31:0], want.weight_a);
        if (tdata[63:32] !== want.weight_b) report("weight_b", tdata[63:32], want.weight_b);
        if (tdata[95:64] !== want.weight_c) report("weight_c", tdata[95:64], want.weight_c);
        if (tdata[96] !== want.inside_res)
            report("inside_res", {31'd0, tdata[96]}, {31'd0, want.inside_res});
        if (tdata[97] !== want.degenerate)
            report("degenerate", {31'd0, tdata[97]}, {31'd0, want.degenerate});
    endtask
endclass

module tb;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int SETTLE = 50;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [15:0]            cfg_data = '0;

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    logic signed [15:0] tri_v [6];

    tri_scoreboard points_sb = new();

    triangle_barycentric_inside_test uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready) points_sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) points_sb.note_point(s_tdata[15:0], s_tdata[31:16]);
            if (m_tvalid && m_tready) points_sb.check_result(m_tdata);
        end
    end

    // result side
    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            gap = $urandom_range(0, 8);
            if (recv_idle && gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task send_point(logic [15:0] px, logic [15:0] py);
        int gap;
        gap = $urandom_range(0, 8);
        if (send_idle && gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // waits for every result, then lets the pipeline drain
    task drain();
        s_tvalid <= 1'b0;
        while (points_sb.pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // writes all vertex registers plus the unused indexes
    task set_triangle(int ax, int ay, int bx, int by, int cx, int cy);
        logic [CFG_IDX_W-1:0] idx [8];
        logic [15:0]          val [8];
        idx = '{REG_A_X, REG_A_Y, REG_B_X, REG_B_Y, REG_C_X, REG_C_Y,
                REG_SPARE_LO, REG_SPARE_HI};
        val = '{ax[15:0], ay[15:0], bx[15:0], by[15:0], cx[15:0], cy[15:0],
                16'($urandom), 16'($urandom)};
        for (int i = 0; i < 6; i++) tri_v[i] = val[i];
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // mostly points in the bounding box of the triangle, some anywhere
    task random_points(int count);
        int xlo, xhi, ylo, yhi;
        xlo = tri_v[0]; xhi = tri_v[0]; ylo = tri_v[1]; yhi = tri_v[1];
        for (int i = 2; i < 6; i += 2)
        begin
            if (tri_v[i] < xlo) xlo = tri_v[i];
            if (tri_v[i] > xhi) xhi = tri_v[i];
            if (tri_v[i+1] < ylo) ylo = tri_v[i+1];
            if (tri_v[i+1] > yhi) yhi = tri_v[i+1];
        end
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                send_point(16'(rand_between(xlo, xhi)), 16'(rand_between(ylo, yhi)));
            else
                send_point(16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        int span;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset triangle is all zero, so degenerate
        send_point(16'h7fff, 16'h8000);
        send_point(16'h8000, 16'h7fff);
        send_point(16'h0000, 16'hffff);
        drain();

        set_triangle(0, 0, 1600, 0, 0, 1600);
        send_point(16'd0, 16'd0);
        send_point(16'd1600, 16'd0);
        send_point(16'd0, 16'd1600);
        send_point(16'd800, 16'd800);
        send_point(16'd400, 16'd400);
        send_point(16'd801, 16'd800);
        send_point(-16'sd1, 16'd5);
        send_point(16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'h8000);
        send_point(16'h7fff, 16'h8000);
        drain();

        set_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
        send_point(16'h8000, 16'h8000);
        send_point(16'h7fff, 16'h7fff);
        send_point(16'h0000, 16'h0000);
        random_points(20);
        drain();

        // collinear vertices
        set_triangle(-100, -200, 100, 200, 300, 600);
        send_point(16'd0, 16'd0);
        send_point(16'd50, 16'hff00);
        drain();

        // half-unit-area triangle, far points saturate
        set_triangle(0, 0, 1, 0, 0, 1);
        send_point(16'h7fff, 16'h0000);
        send_point(16'h8000, 16'h0000);
        send_point(16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'h8000);
        random_points(40);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            send_idle = (ph % 3) != 1;
            recv_idle = (ph % 3) != 2;
            span = (ph < 4) ? 400 : 32767;
            set_triangle(rand_between(-span, span), rand_between(-span, span),
                         rand_between(-span, span), rand_between(-span, span),
                         rand_between(-span, span), rand_between(-span, span));
            random_points(145);
            drain();
        end

        if (points_sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
sv/tbit_pkg.sv
sv/tbit_front.sv
sv/tbit_divider.sv
sv/triangle_barycentric_inside_test.sv
sim/tb.sv
